// ===== rtl/fatags_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and controller states for the FIFO-replacement cache tag store.
package fatags_pkg;

  localparam int LINE_COUNT = 64;
  localparam int ADDR_BITS  = 32;
  localparam int TAG_SHIFT  = 2;
  localparam int TAG_W      = ADDR_BITS - TAG_SHIFT;
  localparam int TOTAL_W    = 32;
  localparam int ADDR_W     = $clog2(LINE_COUNT);
  localparam int CNT_W      = $clog2(LINE_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic hit;
    logic miss;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic exhausted;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/fully_associative_fifo_cache_tags.sv =====
`timescale 1ns / 1ps
// Each access is accepted in the idle state, then scans the filled lines from line 0 upward
// until a tag matches (hit) or every filled line, at most LINE_COUNT, is read (miss), and
// then loads the result register in the done state once that register is free.
// Throughput: one tag is read and compared per cycle from the single read port of the tag RAM,
// and one access is in flight at a time, so the next input transfer waits for the result load.
// Reset clears the fill pointer, fill count, totals and handshake state; tags stay undefined
// and are never read before they are written, so no clearing pass is needed.
module fully_associative_fifo_cache_tags (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fatags_pkg::ADDR_BITS-1:0]  read_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              was_hit,
  output logic [fatags_pkg::TOTAL_W-1:0]    hits_so_far,
  output logic [fatags_pkg::TOTAL_W-1:0]    misses_so_far
);
  import fatags_pkg::*;

  cmd_t    cmd;
  status_t st;

  fatags_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  fatags_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .read_address (read_address),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .was_hit      (was_hit),
    .hits_so_far  (hits_so_far),
    .misses_so_far(misses_so_far)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input transfer accepted while an access is in flight");

  a_match_is_hit: assert property (@(posedge clk) disable iff (rst)
    st.match |-> cmd.hit)
    else $error("tag match not taken as a hit");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_single_update: assert property (@(posedge clk) disable iff (rst)
    (cmd.hit || cmd.miss) |=> !cmd.hit && !cmd.miss)
    else $error("access updated the totals twice");

endmodule

// ===== rtl/fatags_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module fatags_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fatags_dp.sv =====
`timescale 1ns / 1ps
// Datapath: tag RAM, scan index, fill pointer, hit and miss totals and the result register.
module fatags_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [fatags_pkg::ADDR_BITS-1:0]    read_address,
  input  fatags_pkg::cmd_t                    cmd,
  output fatags_pkg::status_t                 st,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                was_hit,
  output logic [fatags_pkg::TOTAL_W-1:0]      hits_so_far,
  output logic [fatags_pkg::TOTAL_W-1:0]      misses_so_far
);
  import fatags_pkg::*;

  logic [TAG_W-1:0]   tag;
  logic [CNT_W-1:0]   idx;
  logic               rd_pending;
  logic [ADDR_W-1:0]  fill_ptr;
  logic [CNT_W-1:0]   fill_count;
  logic [TOTAL_W-1:0] hit_total;
  logic [TOTAL_W-1:0] miss_total;
  logic               result_hit;
  logic [TAG_W-1:0]   rdata;
  logic               issue;
  logic               match;

  // Lines fill in order from zero, so lines below fill_count are exactly the valid ones.
  assign match = rd_pending && (rdata == tag);
  assign issue = cmd.scan && (idx != fill_count) && !match;

  assign st.match     = match;
  assign st.exhausted = !rd_pending && (idx == fill_count);
  assign st.out_free  = !out_valid || !out_stall;

  fatags_ram #(
    .WIDTH(TAG_W),
    .DEPTH(LINE_COUNT)
  ) u_tag_ram (
    .clk  (clk),
    .we   (cmd.miss),
    .waddr(fill_ptr),
    .wdata(tag),
    .re   (issue),
    .raddr(idx[ADDR_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tag <= read_address[ADDR_BITS-1:TAG_SHIFT];
    end
    if (cmd.hit) begin
      result_hit <= 1'b1;
    end else if (cmd.miss) begin
      result_hit <= 1'b0;
    end
    if (cmd.load_out) begin
      was_hit       <= result_hit;
      hits_so_far   <= hit_total;
      misses_so_far <= miss_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      rd_pending <= 1'b0;
      fill_ptr   <= '0;
      fill_count <= '0;
      hit_total  <= '0;
      miss_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= issue;
      if (cmd.start) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.hit) begin
        hit_total <= hit_total + TOTAL_W'(1);
      end
      if (cmd.miss) begin
        miss_total <= miss_total + TOTAL_W'(1);
        if (fill_ptr == ADDR_W'(LINE_COUNT - 1)) begin
          fill_ptr <= '0;
        end else begin
          fill_ptr <= fill_ptr + ADDR_W'(1);
        end
        if (fill_count != CNT_W'(LINE_COUNT)) begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/fatags_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine that sequences the tag scan, the update and the result load.
module fatags_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fatags_pkg::status_t st,
  output fatags_pkg::cmd_t    cmd
);
  import fatags_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.scan = 1'b1;
        if (st.match) begin
          cmd.hit    = 1'b1;
          state_next = ST_DONE;
        end else if (st.exhausted) begin
          cmd.miss   = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait until the result register is empty or its transfer completes now.
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
